/* rtl/fnwm_pkg.sv */
// ----------------------------------------------------------------------------
// fnwm_pkg
// Shared constants, codes and types for the filtered name word matcher.
// ----------------------------------------------------------------------------
package fnwm_pkg;

	// Table sizes
	localparam int MAX_WORDS         = 32;
	localparam int MAX_WORD_LEN      = 16;
	localparam int CLASS_TABLE_DEPTH = 256;

	// Derived widths
	localparam int WORD_IDX_W  = $clog2(MAX_WORDS);
	localparam int CNT_W       = $clog2(MAX_WORDS + 1);
	localparam int POS_IDX_W   = $clog2(MAX_WORD_LEN);
	localparam int LEN_W       = $clog2(MAX_WORD_LEN + 1);
	localparam int WMEM_DEPTH  = MAX_WORDS * MAX_WORD_LEN;
	localparam int WMEM_ADDR_W = WORD_IDX_W + POS_IDX_W;
	localparam int CLASS_IDX_W = $clog2(CLASS_TABLE_DEPTH);

	// Configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_USE_CLASS_TABLE = 2'd0;

	// Input item functions
	localparam logic [1:0] FUNC_SET_CLASS = 2'd0;
	localparam logic [1:0] FUNC_WORD_BYTE = 2'd1;
	localparam logic [1:0] FUNC_NAME_BYTE = 2'd2;

	// Byte classes
	localparam logic [1:0] CLASS_ALLOWED = 2'd0;
	localparam logic [1:0] CLASS_IGNORED = 2'd1;
	localparam logic [1:0] CLASS_BANNED  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_NAME_VERDICT = 2'd0;
	localparam logic [1:0] KIND_WORD_STORED  = 2'd1;
	localparam logic [1:0] KIND_WORD_REJECT  = 2'd2;

	// Class table write request
	typedef struct packed {
		logic                   en;
		logic [CLASS_IDX_W-1:0] idx;
		logic [1:0]             code;
	} class_wr_t;

	// ASCII lowercase
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

/* rtl/fnwm_class_table.sv */
// ----------------------------------------------------------------------------
// fnwm_class_table
// Byte class memory with per-entry valid bits; an entry never written reads
// as allowed. One write port, one registered read port.
// ----------------------------------------------------------------------------
module fnwm_class_table
	import fnwm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  class_wr_t              wr,
	input  logic [CLASS_IDX_W-1:0] rd_idx,
	output logic [1:0]             cls
);

	logic [1:0]                   mem [CLASS_TABLE_DEPTH];
	logic [CLASS_TABLE_DEPTH-1:0] vld_q;
	logic [1:0]                   rd_data_q;
	logic                         rd_vld_q;

	// Write and read the class memory
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.code;
		end
		rd_data_q <= mem[rd_idx];
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_idx];
		end
	end

	assign cls = rd_vld_q ? rd_data_q : CLASS_ALLOWED;

endmodule

/* rtl/filtered_name_word_matcher_top.sv */
// ----------------------------------------------------------------------------
// filtered_name_word_matcher_top
// Banned word loader and name checker with a per-byte class filter.
// ----------------------------------------------------------------------------
// Class writes and banned word bytes never raise busy, so the next item is
// not held off; a word's last byte returns its stored/rejected word on done
// in the next cycle. A name byte holds busy high while one compare unit walks
// the word table: a class lookup state, then per stored word a select state
// plus a memory read and a compare state for each byte compared, one more
// select past the last word unless a match ends the walk, and a closing
// state. A dropped byte goes from the class lookup to the closing state.
// The verdict word appears on done for one cycle right after the closing
// cycle of the name's last byte, when busy is already low. Results cannot be
// held off by the receiver. The tables need no clearing pass after reset.
// ----------------------------------------------------------------------------
module filtered_name_word_matcher_top
	import fnwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Command side
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [7:0]         byte_value,
	input  logic [1:0]         class_code,
	input  logic               last,
	// Result side
	output logic               done,
	output logic [1:0]         kind,
	output logic               banned,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLASS  = 3'd1;
	localparam logic [2:0] ST_WSEL   = 3'd2;
	localparam logic [2:0] ST_RD     = 3'd3;
	localparam logic [2:0] ST_CMP    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]           state_q;
	logic                 use_class_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LEN_W-1:0]     pos_q;
	logic                 too_long_q;
	logic [7:0]           recent_q [MAX_WORD_LEN];
	logic [LEN_W-1:0]     kept_q;
	logic                 refused_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [CNT_W-1:0]     w_q;
	logic [POS_IDX_W-1:0] k_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_mem_q [MAX_WORDS];
	logic [7:0]           word_mem [WMEM_DEPTH];
	logic [7:0]           wrd_q;
	logic                 done_q;
	logic [1:0]           kind_q;
	logic                 banned_q;

	logic                   accept;
	logic                   cfg_wr;
	class_wr_t              cls_wr;
	logic [1:0]             cls;
	logic                   full;
	logic                   ld_over;
	logic                   ld_long_nx;
	logic [LEN_W-1:0]       ld_pos_nx;
	logic                   ld_reject;
	logic                   word_we;
	logic [WMEM_ADDR_W-1:0] word_waddr;
	logic [WMEM_ADDR_W-1:0] word_raddr;
	logic [LEN_W-1:0]       len_m1;
	logic [LEN_W-1:0]       rd_off;
	logic [LEN_W-1:0]       cur_len;
	logic                   keep;
	logic                   ban_byte;
	logic                   cmp_eq;
	logic                   cmp_end;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_USE_CLASS_TABLE);
	assign prdata = (paddr == REG_USE_CLASS_TABLE) ? {{(PDATA_W-1){1'b0}}, use_class_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_class_q <= 1'b1;
		end else if (cfg_wr) begin
			use_class_q <= pwdata[0];
		end
	end

	// Class table
	assign cls_wr.en   = accept && (func == FUNC_SET_CLASS) && (class_code <= CLASS_BANNED);
	assign cls_wr.idx  = byte_value;
	assign cls_wr.code = class_code;

	fnwm_class_table u_class (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cls_wr),
		.rd_idx (byte_value),
		.cls    (cls)
	);

	// Word load progress
	assign full       = (cnt_q >= CNT_W'(MAX_WORDS));
	assign ld_over    = (pos_q >= LEN_W'(MAX_WORD_LEN));
	assign ld_long_nx = too_long_q || ld_over;
	assign ld_pos_nx  = ld_over ? pos_q : pos_q + LEN_W'(1);
	assign ld_reject  = full || ld_long_nx;
	assign word_we    = accept && (func == FUNC_WORD_BYTE) && !ld_over && !full;
	assign word_waddr = {cnt_q[WORD_IDX_W-1:0], pos_q[POS_IDX_W-1:0]};

	// Compare unit addressing: byte len-1-k of word w
	assign len_m1     = len_q - LEN_W'(1);
	assign rd_off     = len_m1 - LEN_W'(k_q);
	assign word_raddr = {w_q[WORD_IDX_W-1:0], rd_off[POS_IDX_W-1:0]};
	assign cur_len    = len_mem_q[w_q[WORD_IDX_W-1:0]];
	assign cmp_eq     = (wrd_q == recent_q[k_q]);
	assign cmp_end    = (LEN_W'(k_q) == len_m1);

	// Name byte filter
	assign keep     = !use_class_q || (cls == CLASS_ALLOWED);
	assign ban_byte = use_class_q && (cls == CLASS_BANNED);

	// Word memory and length table
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[word_waddr] <= to_lower(byte_value);
		end
		wrd_q <= word_mem[word_raddr];
		if (accept && (func == FUNC_WORD_BYTE) && last && !ld_reject) begin
			len_mem_q[cnt_q[WORD_IDX_W-1:0]] <= ld_pos_nx;
		end
	end

	// Kept name bytes, newest at entry 0
	always_ff @(posedge clk) begin
		if (state_q == ST_CLASS && keep) begin
			for (int i = MAX_WORD_LEN - 1; i > 0; i--) begin
				recent_q[i] <= recent_q[i-1];
			end
			recent_q[0] <= to_lower(byte_q);
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= byte_value;
			last_q <= last;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			too_long_q <= 1'b0;
			kept_q     <= '0;
			refused_q  <= 1'b0;
			w_q        <= '0;
			k_q        <= '0;
			len_q      <= '0;
			done_q     <= 1'b0;
			kind_q     <= KIND_NAME_VERDICT;
			banned_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_WORD_BYTE: begin
								if (last) begin
									pos_q      <= '0;
									too_long_q <= 1'b0;
									done_q     <= 1'b1;
									banned_q   <= 1'b0;
									if (ld_reject) begin
										kind_q <= KIND_WORD_REJECT;
									end else begin
										kind_q <= KIND_WORD_STORED;
										cnt_q  <= cnt_q + CNT_W'(1);
									end
								end else begin
									pos_q      <= ld_pos_nx;
									too_long_q <= ld_long_nx;
								end
							end
							FUNC_NAME_BYTE: begin
								// drop any partly loaded word
								pos_q      <= '0;
								too_long_q <= 1'b0;
								state_q    <= ST_CLASS;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLASS: begin
					if (keep) begin
						if (kept_q < LEN_W'(MAX_WORD_LEN)) begin
							kept_q <= kept_q + LEN_W'(1);
						end
						w_q     <= '0;
						state_q <= ST_WSEL;
					end else begin
						if (ban_byte) begin
							refused_q <= 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_WSEL: begin
					// walk stored words; skip empty or too long ones
					if (w_q >= cnt_q) begin
						state_q <= ST_FINISH;
					end else if (cur_len == '0 || cur_len > kept_q) begin
						w_q <= w_q + CNT_W'(1);
					end else begin
						len_q   <= cur_len;
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!cmp_eq) begin
						w_q     <= w_q + CNT_W'(1);
						state_q <= ST_WSEL;
					end else if (cmp_end) begin
						refused_q <= 1'b1;
						state_q   <= ST_FINISH;
					end else begin
						k_q     <= k_q + POS_IDX_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_FINISH: begin
					if (last_q) begin
						done_q    <= 1'b1;
						kind_q    <= KIND_NAME_VERDICT;
						banned_q  <= refused_q || (kept_q == '0);
						kept_q    <= '0;
						refused_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign kind   = kind_q;
	assign banned = banned_q;

endmodule

/* rtl/fnwm_checker.sv */
// ----------------------------------------------------------------------------
// fnwm_checker
// Port-level checks on the matcher's command and result words.
// ----------------------------------------------------------------------------
module fnwm_checker
	import fnwm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       last,
	input logic       done,
	input logic [1:0] kind,
	input logic       banned
);

	// Word results never carry a refusal
	a_word_not_banned: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind != KIND_NAME_VERDICT) |-> !banned)
		else $error("word result with banned set");

	// A class write gives no result
	a_class_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_SET_CLASS) |=> !done)
		else $error("result after class write");

	// A name byte occupies the block
	a_name_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_NAME_BYTE) |=> busy)
		else $error("name byte did not raise busy");

	// A verdict closes a name byte's work
	a_verdict_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == KIND_NAME_VERDICT) |-> $past(busy) && !busy)
		else $error("verdict outside name byte work");

	// A word's last byte is answered in the next cycle
	a_word_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_WORD_BYTE) && last |=>
		done && ((kind == KIND_WORD_STORED) || (kind == KIND_WORD_REJECT)))
		else $error("missing word result");

endmodule

bind filtered_name_word_matcher_top fnwm_checker u_fnwm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.last   (last),
	.done   (done),
	.kind   (kind),
	.banned (banned)
);
